[hw/rtl/assembly_line_tokenizer_assert.svh]
// Assertion helpers used by the tokenizer queue.
`ifndef ASSEMBLY_LINE_TOKENIZER_ASSERT_SVH
`define ASSEMBLY_LINE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ALT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, checked out of reset.
`define ALT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

[hw/rtl/alt_pkg.sv]
package alt_pkg;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_AFTERQ  = 3'd4,
    MODE_SKIP    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_TEND = 2'd1,
    KIND_LEND = 2'd2
  } kind_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CNT_MAX   = 8'hFF;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    logic [7:0] token_number;
    logic       quoted;
  } result_t;

  // One queue entry: everything a single input byte produces.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] m;
    case (c)
      8'h61:   m = 8'h07;  // a
      8'h62:   m = 8'h08;  // b
      8'h66:   m = 8'h0C;  // f
      8'h6E:   m = 8'h0A;  // n
      8'h72:   m = 8'h0D;  // r
      8'h74:   m = 8'h09;  // t
      8'h76:   m = 8'h0B;  // v
      default: m = c;      // quotes, ? and backslash map to themselves
    endcase
    return m;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_COMMA);
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_LF) || (c == CH_CR) || (c == CH_SEMI);
  endfunction

endpackage

[hw/rtl/alt_front.sv]
module alt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      char_byte,
  output logic            push,
  output alt_pkg::entry_t entry
);
  import alt_pkg::*;

  mode_t      mode, mode_next;
  logic [7:0] count, count_next;
  logic [7:0] count_inc;
  logic       nul;

  assign count_inc = (count == CNT_MAX) ? count : count + 8'd1;
  assign nul       = (char_byte == CH_NUL);

  // Next mode and token count.
  always_comb begin
    mode_next  = mode;
    count_next = count;
    case (mode)
      MODE_WORD: begin
        if (is_eol(char_byte)) begin
          count_next = '0;
          mode_next  = nul ? MODE_BETWEEN : MODE_SKIP;
        end else if (is_sep(char_byte)) begin
          count_next = count_inc;
          mode_next  = MODE_BETWEEN;
        end
      end
      MODE_STRING: begin
        if (nul) begin
          count_next = '0;
          mode_next  = MODE_BETWEEN;
        end else if (char_byte == CH_DQUOTE) begin
          count_next = count_inc;
          mode_next  = MODE_AFTERQ;
        end else if (char_byte == CH_BSLASH) begin
          mode_next = MODE_ESCAPE;
        end
      end
      MODE_ESCAPE: begin
        if (nul) begin
          count_next = '0;
          mode_next  = MODE_BETWEEN;
        end else begin
          mode_next = MODE_STRING;
        end
      end
      MODE_SKIP: begin
        if (nul) begin
          count_next = '0;
          mode_next  = MODE_BETWEEN;
        end
      end
      MODE_AFTERQ: begin
        if (is_eol(char_byte)) begin
          count_next = '0;
          mode_next  = nul ? MODE_BETWEEN : MODE_SKIP;
        end else if (is_sep(char_byte)) begin
          mode_next = MODE_BETWEEN;
        end else if (char_byte == CH_DQUOTE) begin
          mode_next = MODE_STRING;
        end
      end
      default: begin
        if (is_eol(char_byte)) begin
          count_next = '0;
          mode_next  = nul ? MODE_BETWEEN : MODE_SKIP;
        end else if (char_byte == CH_DQUOTE) begin
          mode_next = MODE_STRING;
        end else if (!is_sep(char_byte)) begin
          mode_next = MODE_WORD;
        end else begin
          mode_next = MODE_BETWEEN;
        end
      end
    endcase
  end

  // Results produced by this byte.
  always_comb begin
    result_t chr, tend, lend_inc, lend;
    chr      = '{kind: KIND_CHAR, char_value: char_byte, token_number: count, quoted: 1'b0};
    tend     = '{kind: KIND_TEND, char_value: 8'h00, token_number: count, quoted: 1'b0};
    lend_inc = '{kind: KIND_LEND, char_value: 8'h00, token_number: count_inc, quoted: 1'b0};
    lend     = '{kind: KIND_LEND, char_value: 8'h00, token_number: count, quoted: 1'b0};
    push     = 1'b0;
    entry    = '{two: 1'b0, r0: chr, r1: lend_inc};
    case (mode)
      MODE_WORD: begin
        push = 1'b1;
        if (is_eol(char_byte)) begin
          entry.r0  = tend;
          entry.two = 1'b1;
        end else if (is_sep(char_byte)) begin
          entry.r0 = tend;
        end
      end
      MODE_STRING: begin
        chr.quoted  = 1'b1;
        tend.quoted = 1'b1;
        entry.r0    = chr;
        if (nul) begin
          push      = 1'b1;
          entry.r0  = tend;
          entry.two = 1'b1;
        end else if (char_byte == CH_DQUOTE) begin
          push     = 1'b1;
          entry.r0 = tend;
        end else if (char_byte != CH_BSLASH) begin
          push = 1'b1;
        end
      end
      MODE_ESCAPE: begin
        chr.quoted     = 1'b1;
        chr.char_value = map_escape(char_byte);
        tend.quoted    = 1'b1;
        push           = 1'b1;
        entry.r0       = nul ? tend : chr;
        entry.two      = nul;
      end
      MODE_SKIP: begin
        push = 1'b0;
      end
      MODE_AFTERQ: begin
        push     = is_eol(char_byte);
        entry.r0 = lend;
      end
      default: begin
        if (is_eol(char_byte)) begin
          push     = 1'b1;
          entry.r0 = lend;
        end else if (char_byte != CH_DQUOTE && !is_sep(char_byte)) begin
          push = 1'b1;
        end
      end
    endcase
    push = push & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_BETWEEN;
      count <= '0;
    end else if (accept) begin
      mode  <= mode_next;
      count <= count_next;
    end
  end

endmodule

[hw/rtl/alt_queue.sv]
module alt_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  alt_pkg::entry_t wr_entry,
  input  logic            pop,
  output alt_pkg::entry_t head,
  output logic            empty,
  output logic            full
);
  import alt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`include "assembly_line_tokenizer_assert.svh"

  `ALT_ASSERT_NOW(a_no_push_full, push, !full)
  `ALT_ASSERT_NOW(a_no_pop_empty, pop, !empty)
  `ALT_ASSERT_NEXT(a_fill, push && !pop, count == $past(count) + 1'b1)
  `ALT_ASSERT_NEXT(a_drain, pop && !push, count == $past(count) - 1'b1)

endmodule

[hw/rtl/alt_back.sv]
module alt_back (
  input  logic            clk,
  input  logic            rst,
  input  alt_pkg::entry_t head,
  input  logic            empty,
  input  logic            out_stall,
  output logic            pop,
  output logic            out_valid,
  output alt_pkg::result_t res,
  output logic            last
);
  import alt_pkg::*;

  logic phase;  // 1 while the second result of the head entry is shown
  logic take;

  assign out_valid = !empty;
  assign res       = phase ? head.r1 : head.r0;
  assign last      = !head.two || phase;
  assign take      = out_valid && !out_stall;
  assign pop       = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (take) begin
      phase <= !last;
    end
  end

endmodule

[hw/rtl/assembly_line_tokenizer.sv]
// Order: an accepted byte writes its results into the queue, and they are shown at
// its head after earlier entries; a second result (token end followed by line end)
// follows once the first is taken. Throughput: one byte per cycle; a byte with two
// results is absorbed by the QUEUE_DEPTH-entry queue; a full queue stalls input.
// Reset (rst, synchronous): between tokens at start of line, token count zero,
// queue empty.
module assembly_line_tokenizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] char_value,
  output logic [7:0] token_number,
  output logic       quoted,
  output logic       last
);
  import alt_pkg::*;

  logic    accept;
  logic    push, pop, empty, full;
  entry_t  wr_entry, head;
  result_t res;

  // Stall input only when the queue has no room; the back end drains it on
  // its own schedule.
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  // Front: advance the lexer mode and build the results of each transaction.
  alt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_byte (char_byte),
    .push      (push),
    .entry     (wr_entry)
  );

  // Queue: hold one entry per byte that produced any result.
  alt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Back: serialize each entry into one or two output transactions.
  alt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .out_stall (out_stall),
    .pop       (pop),
    .out_valid (out_valid),
    .res       (res),
    .last      (last)
  );

  assign kind         = 2'(res.kind);
  assign char_value   = res.char_value;
  assign token_number = res.token_number;
  assign quoted       = res.quoted;

endmodule
